>>> design/deq_pkg.sv
// deq_pkg: types, constants and index helpers for the double-ended queue
// used by deq_ctrl, deq_datapath and double_ended_queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W   = COUNT_W + 1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [DATA_W-1:0]  data_t;

	typedef enum logic [1:0] {
		FUNC_PUSH_RIGHT = 2'd0,
		FUNC_POP_LEFT   = 2'd1,
		FUNC_POP_RIGHT  = 2'd2,
		FUNC_STATUS     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SETTLE,
		ST_RESP
	} state_t;

	typedef struct packed {
		func_t func;
		data_t item;
	} req_t;

	typedef struct packed {
		data_t  popped_item;
		logic   op_error;
		data_t  left_item;
		data_t  right_item;
		logic   is_empty;
		logic   is_full;
		count_t item_count;
	} result_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_t;

	// base + offset modulo DEPTH, base below DEPTH and offset at most DEPTH
	function automatic idx_t wrap_add(idx_t base, count_t offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

`default_nettype wire

>>> design/deq_ram.sv
// deq_ram: generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic      [WIDTH-1:0]                      rdata_a,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic      [WIDTH-1:0]                      rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

>>> design/deq_ctrl.sv
// deq_ctrl: transaction sequencer for the double-ended queue
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output deq_pkg::ctrl_t     cmd
);

	deq_pkg::state_t state_q;
	deq_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				if (start) begin
					state_next = deq_pkg::ST_EXEC;
				end
			end
			deq_pkg::ST_EXEC:   state_next = deq_pkg::ST_SETTLE;
			deq_pkg::ST_SETTLE: state_next = deq_pkg::ST_RESP;
			deq_pkg::ST_RESP:   state_next = deq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		done        = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			deq_pkg::ST_EXEC:   cmd.execute = 1'b1;
			deq_pkg::ST_SETTLE: ;
			deq_pkg::ST_RESP:   done = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

>>> design/deq_datapath.sv
// deq_datapath: pointers, fill count, slot ram and result formation
// depends on deq_pkg and deq_ram
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire deq_pkg::ctrl_t   cmd,
	input  wire deq_pkg::req_t    req,
	output deq_pkg::result_t      result
);

	deq_pkg::func_t  func_q;
	deq_pkg::data_t  item_q;
	deq_pkg::idx_t   left_q;
	deq_pkg::count_t count_q;
	deq_pkg::data_t  popped_q;
	logic            error_q;

	deq_pkg::idx_t   left_idx;
	deq_pkg::idx_t   right_idx;
	deq_pkg::idx_t   push_idx;
	deq_pkg::data_t  left_rd;
	deq_pkg::data_t  right_rd;
	logic            is_empty;
	logic            is_full;
	logic            push_we;

	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == deq_pkg::COUNT_W'(deq_pkg::DEPTH));
	assign left_idx  = left_q;
	assign right_idx = deq_pkg::wrap_add(left_q, count_q - 1'b1);
	assign push_idx  = deq_pkg::wrap_add(left_q, count_q);
	assign push_we   = cmd.execute && (func_q == deq_pkg::FUNC_PUSH_RIGHT) && !is_full;

	deq_ram #(
		.WIDTH (deq_pkg::DATA_W),
		.DEPTH (deq_pkg::DEPTH)
	) u_slots (
		.clk     (clk),
		.we      (push_we),
		.waddr   (push_idx),
		.wdata   (item_q),
		.raddr_a (left_idx),
		.rdata_a (left_rd),
		.raddr_b (right_idx),
		.rdata_b (right_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req.func;
			item_q <= req.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			count_q  <= '0;
			popped_q <= '0;
			error_q  <= 1'b0;
		end else if (cmd.execute) begin
			unique case (func_q)
				deq_pkg::FUNC_PUSH_RIGHT: begin
					popped_q <= '0;
					error_q  <= is_full;
					if (!is_full) begin
						count_q <= count_q + 1'b1;
					end
				end
				deq_pkg::FUNC_POP_LEFT: begin
					error_q <= is_empty;
					if (is_empty) begin
						popped_q <= '0;
					end else begin
						popped_q <= left_rd;
						left_q   <= deq_pkg::wrap_add(left_q, deq_pkg::COUNT_W'(1));
						count_q  <= count_q - 1'b1;
					end
				end
				deq_pkg::FUNC_POP_RIGHT: begin
					error_q <= is_empty;
					if (is_empty) begin
						popped_q <= '0;
					end else begin
						popped_q <= right_rd;
						count_q  <= count_q - 1'b1;
					end
				end
				deq_pkg::FUNC_STATUS: begin
					popped_q <= '0;
					error_q  <= 1'b0;
				end
			endcase
		end
	end

	// peeks read zero when nothing is held
	always_comb begin
		result.popped_item = popped_q;
		result.op_error    = error_q;
		result.left_item   = is_empty ? '0 : left_rd;
		result.right_item  = is_empty ? '0 : right_rd;
		result.is_empty    = is_empty;
		result.is_full     = is_full;
		result.item_count  = count_q;
	end

endmodule

`default_nettype wire

>>> design/double_ended_queue.sv
// double_ended_queue: top level of the ring-buffer double-ended queue
// depends on deq_pkg, deq_ctrl, deq_datapath and deq_ram
//
// usage:
//   a request transaction (req.func, req.item) is taken at a rising edge
//   where start is high and busy is low. func selects push right, pop
//   left, pop right or status only; item is used by a push.
//   every request gives one result transaction: result is valid for the
//   single cycle in which done is high, and the receiver cannot stall it.
//   done is high in ST_RESP, after the ST_EXEC and ST_SETTLE states that
//   follow the accepting edge; busy drops in the cycle after done, so a
//   new request is not taken before the last one is through. the slot
//   ram sets the sequence: the current ends are read, pointers updated and
//   the slot written, then the new ends read after the write.
//   pop on empty and push on full set op_error and leave the queue alone.
//   reset empties the queue (left pointer and fill count cleared); the
//   slot ram is not cleared, since only held entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire deq_pkg::req_t    req,
	output logic                  done,
	output deq_pkg::result_t      result
);

	deq_pkg::ctrl_t cmd;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	deq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.result (result)
	);

endmodule

`default_nettype wire

>>> verif/tb_double_ended_queue.sv
// tb_double_ended_queue: self-checking testbench for the ring-buffer double-ended queue
// holds its own prediction of the queue state; depends on deq_pkg and double_ended_queue
`timescale 1ns / 1ps

class deque_tracker;
	deq_pkg::data_t   slot_copy [deq_pkg::DEPTH];
	int               left_pos = 0;
	int               held = 0;
	deq_pkg::result_t pending_results [$];
	int               mismatches = 0;
	int               checked = 0;
	int               func_seen [4] = '{0, 0, 0, 0};
	int               rejected = 0;
	int               full_seen = 0;
	int               empty_seen = 0;

	function void note_request(deq_pkg::req_t r);
		deq_pkg::result_t res;
		res = '0;
		func_seen[int'(r.func)]++;
		case (r.func)
			deq_pkg::FUNC_PUSH_RIGHT: begin
				if (held == deq_pkg::DEPTH) begin
					res.op_error = 1'b1;
				end else begin
					slot_copy[(left_pos + held) % deq_pkg::DEPTH] = r.item;
					held++;
				end
			end
			deq_pkg::FUNC_POP_LEFT: begin
				if (held == 0) begin
					res.op_error = 1'b1;
				end else begin
					res.popped_item = slot_copy[left_pos];
					left_pos = (left_pos + 1) % deq_pkg::DEPTH;
					held--;
				end
			end
			deq_pkg::FUNC_POP_RIGHT: begin
				if (held == 0) begin
					res.op_error = 1'b1;
				end else begin
					res.popped_item = slot_copy[(left_pos + held - 1) % deq_pkg::DEPTH];
					held--;
				end
			end
			default: begin
			end
		endcase
		if (held != 0) begin
			res.left_item  = slot_copy[left_pos];
			res.right_item = slot_copy[(left_pos + held - 1) % deq_pkg::DEPTH];
		end
		res.is_empty   = (held == 0);
		res.is_full    = (held == deq_pkg::DEPTH);
		res.item_count = deq_pkg::count_t'(held);
		if (res.op_error) rejected++;
		if (res.is_full) full_seen++;
		if (res.is_empty) empty_seen++;
		pending_results = {pending_results, res};
	endfunction

	function void compare_field(string name, logic [31:0] e, logic [31:0] a);
		if (a !== e) begin
			mismatches++;
			if (mismatches <= 40) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
			end
		end
	endfunction

	function void check_result(deq_pkg::result_t act);
		deq_pkg::result_t exp;
		if (pending_results.size() == 0) begin
			mismatches++;
			$display("%0t: result with no transaction outstanding, expected none, got %h",
				$time, act);
			return;
		end
		exp = pending_results.pop_front();
		checked++;
		compare_field("popped_item", exp.popped_item, act.popped_item);
		compare_field("op_error", 32'(exp.op_error), 32'(act.op_error));
		compare_field("left_item", exp.left_item, act.left_item);
		compare_field("right_item", exp.right_item, act.right_item);
		compare_field("is_empty", 32'(exp.is_empty), 32'(act.is_empty));
		compare_field("is_full", 32'(exp.is_full), 32'(act.is_full));
		compare_field("item_count", 32'(exp.item_count), 32'(act.item_count));
	endfunction
endclass

module tb_double_ended_queue;

	localparam int RANDOM_ITEMS = 1600;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	deq_pkg::req_t    req = '0;
	logic             busy;
	logic             done;
	deq_pkg::result_t result;
	int               stall_cycles = 0;

	deque_tracker tracker;

	double_ended_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) tracker.note_request(req);
			if (done) tracker.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_request(input deq_pkg::func_t f, input deq_pkg::data_t d);
		start <= 1'b1;
		req   <= '{func: f, item: d};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic maybe_idle(input bit allow);
		int gap;
		if (allow && $urandom_range(0, 99) < 22) begin
			gap = $urandom_range(1, 7);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int              push_pct;
		int              mode_left;
		int              pick;
		deq_pkg::func_t  f;
		deq_pkg::data_t  d;
		tracker = new;
		push_pct = 50;
		mode_left = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: status, then both pops rejected
		send_request(deq_pkg::FUNC_STATUS, 32'h0);
		maybe_idle(1'b1);
		send_request(deq_pkg::FUNC_POP_LEFT, $urandom);
		maybe_idle(1'b1);
		send_request(deq_pkg::FUNC_POP_RIGHT, $urandom);
		for (int k = 0; k < deq_pkg::DEPTH; k++) begin
			case (k)
				0:       d = 32'h0000_0000;
				1:       d = 32'hFFFF_FFFF;
				2:       d = 32'h5555_5555;
				3:       d = 32'hAAAA_AAAA;
				default: d = $urandom;
			endcase
			maybe_idle(1'b1);
			send_request(deq_pkg::FUNC_PUSH_RIGHT, d);
		end
		// full queue: push rejected, status, then pops from both ends and a push into the freed slot
		maybe_idle(1'b1);
		send_request(deq_pkg::FUNC_PUSH_RIGHT, 32'hDEAD_BEEF);
		maybe_idle(1'b1);
		send_request(deq_pkg::FUNC_STATUS, $urandom);
		maybe_idle(1'b1);
		send_request(deq_pkg::FUNC_POP_LEFT, $urandom);
		maybe_idle(1'b1);
		send_request(deq_pkg::FUNC_POP_RIGHT, $urandom);
		maybe_idle(1'b1);
		send_request(deq_pkg::FUNC_PUSH_RIGHT, $urandom);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (mode_left == 0) begin
				case ($urandom_range(0, 2))
					0:       push_pct = 75;
					1:       push_pct = 25;
					default: push_pct = 48;
				endcase
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			pick = $urandom_range(0, 99);
			if (pick < push_pct) begin
				f = deq_pkg::FUNC_PUSH_RIGHT;
			end else if (pick < 92) begin
				f = ($urandom_range(0, 1) == 0) ? deq_pkg::FUNC_POP_LEFT
					: deq_pkg::FUNC_POP_RIGHT;
			end else begin
				f = deq_pkg::FUNC_STATUS;
			end
			maybe_idle(!(i >= 500 && i < 800));
			send_request(f, $urandom);
		end
		start <= 1'b0;

		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d results checked: %0d push, %0d pop left, %0d pop right, %0d status",
			tracker.checked, tracker.func_seen[int'(deq_pkg::FUNC_PUSH_RIGHT)],
			tracker.func_seen[int'(deq_pkg::FUNC_POP_LEFT)],
			tracker.func_seen[int'(deq_pkg::FUNC_POP_RIGHT)],
			tracker.func_seen[int'(deq_pkg::FUNC_STATUS)]);
		$display("%0d rejected, %0d results full, %0d results empty, %0d mismatches",
			tracker.rejected, tracker.full_seen, tracker.empty_seen, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
